// ----- sv/aabbxf_pkg.sv -----
// ----------------------------------------------------------------------------
// aabbxf_pkg
// Shared types and constants of the box affine transform unit.
// ----------------------------------------------------------------------------
package aabbxf_pkg;

  // coordinate and field widths
  localparam int COORD_WIDTH = 32;
  localparam int FIELD_W     = 32;
  localparam int COEF_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int REG_W       = 64;
  localparam int NUM_AXES    = 3;
  localparam int CFG_IDX_W   = 3;

  // exact product, sum of three products plus translation, shifted sum
  localparam int PROD_W  = COORD_WIDTH + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SHIFT_W = SUM_W - FRAC_BITS;

  localparam int PIPE_DEPTH = 4;

  // clamp bounds of a COORD_WIDTH-bit signed value at the shifted width
  localparam logic signed [SHIFT_W-1:0] CLAMP_TOP =
    {{(SHIFT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SHIFT_W-1:0] CLAMP_BOT = ~CLAMP_TOP;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ROW_LOW  = 3'd0,
    REG_X_ROW_HIGH = 3'd1,
    REG_Y_ROW_LOW  = 3'd2,
    REG_Y_ROW_HIGH = 3'd3,
    REG_Z_ROW_LOW  = 3'd4,
    REG_Z_ROW_HIGH = 3'd5
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_X_ROW_LOW  = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_X_ROW_HIGH = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_Y_ROW_LOW  = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_Y_ROW_HIGH = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_Z_ROW_LOW  = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_Z_ROW_HIGH = 64'h0000_0000_0001_0000;

  // one matrix row: low = {coef y, coef x}, high = {translation, coef z}
  typedef struct packed {
    logic [REG_W-1:0] low;
    logic [REG_W-1:0] high;
  } row_coef_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] box_min_x;
    logic signed [FIELD_W-1:0] box_min_y;
    logic signed [FIELD_W-1:0] box_min_z;
    logic signed [FIELD_W-1:0] box_max_x;
    logic signed [FIELD_W-1:0] box_max_y;
    logic signed [FIELD_W-1:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_min_x;
    logic signed [FIELD_W-1:0] out_min_y;
    logic signed [FIELD_W-1:0] out_min_z;
    logic signed [FIELD_W-1:0] out_max_x;
    logic signed [FIELD_W-1:0] out_max_y;
    logic signed [FIELD_W-1:0] out_max_z;
    logic                      saturated;
  } result_t;

endpackage

// ----- sv/aabbxf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// aabbxf_cfg_regs
// Holds the 3x4 matrix as six 64-bit registers, written by index.
// ----------------------------------------------------------------------------
module aabbxf_cfg_regs (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        wr_en,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]            wr_index,
  input  logic [aabbxf_pkg::REG_W-1:0]                wr_data,
  output aabbxf_pkg::row_coef_t [aabbxf_pkg::NUM_AXES-1:0] coef
);

  aabbxf_pkg::row_coef_t [aabbxf_pkg::NUM_AXES-1:0] coef_r;
  aabbxf_pkg::row_coef_t [aabbxf_pkg::NUM_AXES-1:0] coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      unique case (wr_index)
        aabbxf_pkg::REG_X_ROW_LOW:  coef_nxt[0].low  = wr_data;
        aabbxf_pkg::REG_X_ROW_HIGH: coef_nxt[0].high = wr_data;
        aabbxf_pkg::REG_Y_ROW_LOW:  coef_nxt[1].low  = wr_data;
        aabbxf_pkg::REG_Y_ROW_HIGH: coef_nxt[1].high = wr_data;
        aabbxf_pkg::REG_Z_ROW_LOW:  coef_nxt[2].low  = wr_data;
        aabbxf_pkg::REG_Z_ROW_HIGH: coef_nxt[2].high = wr_data;
        default:                    coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0].low  <= aabbxf_pkg::RST_X_ROW_LOW;
      coef_r[0].high <= aabbxf_pkg::RST_X_ROW_HIGH;
      coef_r[1].low  <= aabbxf_pkg::RST_Y_ROW_LOW;
      coef_r[1].high <= aabbxf_pkg::RST_Y_ROW_HIGH;
      coef_r[2].low  <= aabbxf_pkg::RST_Z_ROW_LOW;
      coef_r[2].high <= aabbxf_pkg::RST_Z_ROW_HIGH;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ----- sv/aabbxf_row.sv -----
// ----------------------------------------------------------------------------
// aabbxf_row
// One output axis: four-stage pipeline giving the floor-shifted, clamped
// minimum and maximum of a matrix row over all eight box corners.
// ----------------------------------------------------------------------------
module aabbxf_row (
  input  logic                                                          clk,
  input  aabbxf_pkg::row_coef_t                                         coef,
  input  logic [aabbxf_pkg::NUM_AXES-1:0][aabbxf_pkg::COORD_WIDTH-1:0] lo,
  input  logic [aabbxf_pkg::NUM_AXES-1:0][aabbxf_pkg::COORD_WIDTH-1:0] hi,
  output logic signed [aabbxf_pkg::COORD_WIDTH-1:0]                     min_o,
  output logic signed [aabbxf_pkg::COORD_WIDTH-1:0]                     max_o,
  output logic                                                          sat_o
);

  localparam int PW = aabbxf_pkg::PROD_W;
  localparam int SW = aabbxf_pkg::SUM_W;
  localparam int HW = aabbxf_pkg::SHIFT_W;
  localparam int CW = aabbxf_pkg::COORD_WIDTH;
  localparam int NA = aabbxf_pkg::NUM_AXES;

  logic signed [aabbxf_pkg::COEF_W-1:0] c [NA];
  logic signed [aabbxf_pkg::COEF_W-1:0] trans;
  logic signed [SW-1:0]                 trans_ext;

  assign c[0]  = coef.low[aabbxf_pkg::COEF_W-1:0];
  assign c[1]  = coef.low[2*aabbxf_pkg::COEF_W-1:aabbxf_pkg::COEF_W];
  assign c[2]  = coef.high[aabbxf_pkg::COEF_W-1:0];
  assign trans = coef.high[2*aabbxf_pkg::COEF_W-1:aabbxf_pkg::COEF_W];
  // translation times 1.0 in Q16.16
  assign trans_ext = SW'($signed({trans, {aabbxf_pkg::FRAC_BITS{1'b0}}}));

  // stage 1: exact products of each coefficient with both box ends
  logic signed [PW-1:0] plo_r [NA];
  logic signed [PW-1:0] phi_r [NA];

  always_ff @(posedge clk) begin
    for (int a = 0; a < NA; a++) begin
      plo_r[a] <= c[a] * $signed(lo[a]);
      phi_r[a] <= c[a] * $signed(hi[a]);
    end
  end

  // stage 2: per term, the smaller and larger product; the extremes of the
  // row are separable over the terms, so no corner is formed explicitly
  logic signed [PW-1:0] tmin [NA];
  logic signed [PW-1:0] tmax [NA];
  logic signed [SW-1:0] pmin_r, pmax_r;
  logic signed [PW-1:0] min2_r, max2_r;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      tmin[a] = (plo_r[a] < phi_r[a]) ? plo_r[a] : phi_r[a];
      tmax[a] = (plo_r[a] < phi_r[a]) ? phi_r[a] : plo_r[a];
    end
  end

  always_ff @(posedge clk) begin
    pmin_r <= SW'(tmin[0]) + SW'(tmin[1]);
    pmax_r <= SW'(tmax[0]) + SW'(tmax[1]);
    min2_r <= tmin[2];
    max2_r <= tmax[2];
  end

  // stage 3: full-precision row sums
  logic signed [SW-1:0] smin_r, smax_r;

  always_ff @(posedge clk) begin
    smin_r <= pmin_r + SW'(min2_r) + trans_ext;
    smax_r <= pmax_r + SW'(max2_r) + trans_ext;
  end

  // stage 4: floor shift and clamp
  logic signed [HW-1:0] shmin, shmax;
  logic signed [CW-1:0] min_r, max_r, min_nxt, max_nxt;
  logic                 sat_r, sat_nxt;

  always_comb begin
    shmin = smin_r[SW-1:aabbxf_pkg::FRAC_BITS];
    shmax = smax_r[SW-1:aabbxf_pkg::FRAC_BITS];
    sat_nxt = 1'b0;
    min_nxt = shmin[CW-1:0];
    max_nxt = shmax[CW-1:0];
    if (shmin > aabbxf_pkg::CLAMP_TOP) begin
      min_nxt = aabbxf_pkg::CLAMP_TOP[CW-1:0];
      sat_nxt = 1'b1;
    end else if (shmin < aabbxf_pkg::CLAMP_BOT) begin
      min_nxt = aabbxf_pkg::CLAMP_BOT[CW-1:0];
      sat_nxt = 1'b1;
    end
    if (shmax > aabbxf_pkg::CLAMP_TOP) begin
      max_nxt = aabbxf_pkg::CLAMP_TOP[CW-1:0];
      sat_nxt = 1'b1;
    end else if (shmax < aabbxf_pkg::CLAMP_BOT) begin
      max_nxt = aabbxf_pkg::CLAMP_BOT[CW-1:0];
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    sat_r <= sat_nxt;
  end

  assign min_o = min_r;
  assign max_o = max_r;
  assign sat_o = sat_r;

endmodule

// ----- sv/aabb_affine_transform_unit.sv -----
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// Transforms an axis-aligned box by a 3x4 affine matrix and returns the
// bounding box of the eight transformed corners, with saturation flag.
// ----------------------------------------------------------------------------
// Usage:
//   input: drive in_box and raise start; a beat is taken at an edge with
//   start high and busy low. busy is high during reset and in the first
//   cycle after it, then stays low, so a new box can be given every cycle.
//   output: out_valid strobes for one cycle with out_result; the receiver
//   takes the beat in that cycle and cannot hold it off.
//   pipeline: the result of a beat passes four register stages (products,
//   term select and first add, full row sum, floor shift and clamp).
//   Throughput one box per cycle, set by the 18 parallel 32x32 multipliers
//   of the first stage.
//   config: cfg_valid/cfg_ready writes cfg_data into register cfg_index
//   (x, y, z rows, low then high half); indexes past the map are dropped.
//   Write only while no beat is in flight.
//   reset: synchronous; the matrix returns to identity and in-flight beats
//   are dropped.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  aabbxf_pkg::box_t                    in_box,
  output logic                                out_valid,
  output aabbxf_pkg::result_t                 out_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aabbxf_pkg::REG_W-1:0]        cfg_data
);

  localparam int CW = aabbxf_pkg::COORD_WIDTH;
  localparam int NA = aabbxf_pkg::NUM_AXES;
  localparam int FW = aabbxf_pkg::FIELD_W;

  logic busy_r, busy_nxt;
  logic accept;
  logic [aabbxf_pkg::PIPE_DEPTH-1:0] vld_r, vld_nxt;

  assign busy_nxt = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start & ~busy_r;
  assign vld_nxt   = {vld_r[aabbxf_pkg::PIPE_DEPTH-2:0], accept};
  assign out_valid = vld_r[aabbxf_pkg::PIPE_DEPTH-1];

  aabbxf_pkg::row_coef_t [NA-1:0] coef;

  aabbxf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  // only the low COORD_WIDTH bits of each coordinate take part
  logic [NA-1:0][CW-1:0] lo, hi;

  assign lo[0] = in_box.box_min_x[CW-1:0];
  assign lo[1] = in_box.box_min_y[CW-1:0];
  assign lo[2] = in_box.box_min_z[CW-1:0];
  assign hi[0] = in_box.box_max_x[CW-1:0];
  assign hi[1] = in_box.box_max_y[CW-1:0];
  assign hi[2] = in_box.box_max_z[CW-1:0];

  logic signed [CW-1:0] row_min [NA];
  logic signed [CW-1:0] row_max [NA];
  logic [NA-1:0]        row_sat;

  for (genvar r = 0; r < NA; r++) begin : g_row
    aabbxf_row u_row (
      .clk   (clk),
      .coef  (coef[r]),
      .lo    (lo),
      .hi    (hi),
      .min_o (row_min[r]),
      .max_o (row_max[r]),
      .sat_o (row_sat[r])
    );
  end

  assign out_result.out_min_x = FW'(row_min[0]);
  assign out_result.out_min_y = FW'(row_min[1]);
  assign out_result.out_min_z = FW'(row_min[2]);
  assign out_result.out_max_x = FW'(row_max[0]);
  assign out_result.out_max_y = FW'(row_max[1]);
  assign out_result.out_max_z = FW'(row_max[2]);
  assign out_result.saturated = |row_sat;

`ifndef NO_ASSERTIONS
  // every result beat comes from an input beat taken with start high and busy low
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result beat without matching input beat");

  // clamping is monotonic, so the bounds never cross
  a_x_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.out_min_x <= out_result.out_max_x)
    else $error("x bounds crossed");

  a_y_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.out_min_y <= out_result.out_max_y)
    else $error("y bounds crossed");

  a_z_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.out_min_z <= out_result.out_max_z)
    else $error("z bounds crossed");
`endif

endmodule
